>>> src/fqi_pkg.sv
// Package for the queue with positional insert and remove.
// Holds the request codes, the per-cell shift codes and the fixed field widths.
// Depends on nothing; used by fqi_cell and fifo_queue_with_positional_insert.
`timescale 1ns / 1ps
`default_nettype none

package fqi_pkg;

    // Fixed widths of the request and result fields
    localparam int ACT_BITS  = 3;
    localparam int DATA_BITS = 32;
    localparam int IDX_BITS  = 5;
    localparam int CNT_BITS  = 5;

    // Request codes; the spare codes are rejected
    typedef enum logic [ACT_BITS-1:0] {
        ACT_PUSH   = 3'd0,
        ACT_POP    = 3'd1,
        ACT_PEEK   = 3'd2,
        ACT_INSERT = 3'd3,
        ACT_REMOVE = 3'd4
    } t_action;

    // Move broadcast to every cell of the chain
    typedef enum logic [1:0] {
        SHIFT_NONE   = 2'd0,
        SHIFT_INSERT = 2'd1,
        SHIFT_REMOVE = 2'd2
    } t_shift;

endpackage

`default_nettype wire

>>> src/fqi_cell.sv
// One storage cell of the queue chain.
// Holds a word and, on the broadcast move, loads the new word or takes its neighbour's.
// Depends on fqi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fqi_cell #(
    parameter int CELL_IDX  = 0,
    parameter int IW        = 4,
    parameter int WORD_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire fqi_pkg::t_shift      i_shift,
    input  wire logic [IW-1:0]        i_pos,
    input  wire logic [WORD_BITS-1:0] i_value,
    input  wire logic [WORD_BITS-1:0] i_left,
    input  wire logic [WORD_BITS-1:0] i_right,
    output logic      [WORD_BITS-1:0] o_word
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic [WORD_BITS-1:0] r_word;
    logic [WORD_BITS-1:0] n_word;

    // Choose hold, load, or take from a neighbour
    always_comb begin
        n_word = r_word;
        unique case (i_shift)
            fqi_pkg::SHIFT_INSERT: begin
                if (MY_IDX == i_pos) begin
                    n_word = i_value;
                end else if (MY_IDX > i_pos) begin
                    n_word = i_left;
                end
            end
            fqi_pkg::SHIFT_REMOVE: begin
                if (MY_IDX >= i_pos) begin
                    n_word = i_right;
                end
            end
            default: begin
                n_word = r_word;
            end
        endcase
    end

    // Payload register, no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

>>> src/fifo_queue_with_positional_insert.sv
// Top level of the queue with positional insert and remove: decoder, chain of cells, result.
// Depends on fqi_pkg and fqi_cell.
// The result of a request is registered and appears in the cycle after it is accepted, strobed by o_done.
// Throughput: one request per cycle; busy stays low, as all cells shift in parallel.
// Reset (synchronous, active low) empties the queue and clears the strobe; cell contents
// stay undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module fifo_queue_with_positional_insert #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [fqi_pkg::ACT_BITS-1:0]        i_action,
    input  wire logic signed [fqi_pkg::DATA_BITS-1:0] i_value,
    input  wire logic [fqi_pkg::IDX_BITS-1:0]        i_index,
    output logic                                     o_done,
    output logic signed [fqi_pkg::DATA_BITS-1:0]     o_data,
    output logic                                     o_ok,
    output logic [fqi_pkg::CNT_BITS-1:0]             o_count
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > fqi_pkg::IDX_BITS) ? CW : fqi_pkg::IDX_BITS;
    localparam int EW = 64;
    localparam logic [CW-1:0] FULL_FILL = CW'(DEPTH);

    logic                 r_done;
    logic                 r_ok;
    logic [fqi_pkg::DATA_BITS-1:0] r_data;
    logic [fqi_pkg::CNT_BITS-1:0]  r_count;
    logic [CW-1:0]        r_fill;
    logic [CW-1:0]        n_fill;

    logic                 accept;
    fqi_pkg::t_action     action;
    fqi_pkg::t_shift      shift;
    logic [IW-1:0]        pos;
    logic                 ok;
    logic                 rd;
    logic                 full;
    logic                 empty;
    logic [XW-1:0]        idx_x;
    logic [XW-1:0]        fill_x;
    logic [XW-1:0]        nfill_x;
    logic [WORD_BITS-1:0] store_val;
    logic signed [EW-1:0] value_ext;
    logic signed [EW-1:0] read_ext;
    logic [fqi_pkg::DATA_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] cell_word [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign action = fqi_pkg::t_action'(i_action);
    assign full   = (r_fill == FULL_FILL);
    assign empty  = (r_fill == '0);
    assign idx_x  = XW'(i_index);
    assign fill_x = XW'(r_fill);

    // Trim the request word to the stored width, sign-extending first
    assign value_ext = EW'(i_value);
    assign store_val = value_ext[WORD_BITS-1:0];

    // Decode the request into a move, a position and the result flags
    always_comb begin
        ok    = 1'b0;
        rd    = 1'b0;
        pos   = '0;
        shift = fqi_pkg::SHIFT_NONE;
        unique case (action)
            fqi_pkg::ACT_PUSH: begin
                ok    = !full;
                pos   = r_fill[IW-1:0];
                shift = fqi_pkg::SHIFT_INSERT;
            end
            fqi_pkg::ACT_POP: begin
                ok    = !empty;
                rd    = 1'b1;
                shift = fqi_pkg::SHIFT_REMOVE;
            end
            fqi_pkg::ACT_PEEK: begin
                ok = !empty;
                rd = 1'b1;
            end
            fqi_pkg::ACT_INSERT: begin
                ok    = !full && (idx_x <= fill_x);
                pos   = idx_x[IW-1:0];
                shift = fqi_pkg::SHIFT_INSERT;
            end
            fqi_pkg::ACT_REMOVE: begin
                ok    = (idx_x < fill_x);
                rd    = 1'b1;
                pos   = idx_x[IW-1:0];
                shift = fqi_pkg::SHIFT_REMOVE;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (!(accept && ok)) begin
            shift = fqi_pkg::SHIFT_NONE;
        end
    end

    // Advance the fill count
    always_comb begin
        n_fill = r_fill;
        unique case (shift)
            fqi_pkg::SHIFT_INSERT: n_fill = r_fill + CW'(1);
            fqi_pkg::SHIFT_REMOVE: n_fill = r_fill - CW'(1);
            default:               n_fill = r_fill;
        endcase
    end
    assign nfill_x = XW'(n_fill);

    // Read the addressed cell and sign-extend it to the result width
    assign read_ext = EW'(signed'(cell_word[pos]));
    assign rd_data  = (ok && rd) ? read_ext[fqi_pkg::DATA_BITS-1:0] : '0;

    // Chain of cells; the ends take the new word on the left and hold on the right
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        fqi_cell #(
            .CELL_IDX  (g),
            .IW        (IW),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (shift),
            .i_pos   (pos),
            .i_value (store_val),
            .i_left  ((g == 0) ? store_val : cell_word[(g == 0) ? 0 : g - 1]),
            .i_right ((g == DEPTH - 1) ? cell_word[g] : cell_word[(g == DEPTH - 1) ? g : g + 1]),
            .o_word  (cell_word[g])
        );
    end

    // Control state: fill count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_done <= 1'b0;
        end else begin
            r_fill <= n_fill;
            r_done <= accept;
        end
    end

    // Result payload, captured with each request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ok    <= ok;
            r_data  <= rd_data;
            r_count <= nfill_x[fqi_pkg::CNT_BITS-1:0];
        end
    end

    assign o_done  = r_done;
    assign o_ok    = r_ok;
    assign o_data  = r_data;
    assign o_count = r_count;

    // Fill count never passes the depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_FILL)
        else $error("fill count above depth");

    // Every accepted request yields a result in the next cycle
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("request without result");

    // A rejected request leaves the fill count unchanged
    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (r_fill == $past(r_fill)))
        else $error("rejected request changed the queue");

    // A rejected request carries zero data
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_data == '0))
        else $error("rejected request returned data");

    // A push into a queue with room grows it by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (action == fqi_pkg::ACT_PUSH) && !full)
        |=> (r_fill == $past(r_fill) + CW'(1)))
        else $error("push did not grow the queue");

endmodule

`default_nettype wire
